// ===== hw/rtl/ccl_pkg.sv =====
// Shared types and constants for the clock command line parser.
`default_nettype none

package ccl_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_OPEN  = 8'h28;
    localparam byte_t CH_CLOSE = 8'h29;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;

    localparam logic [2:0] EV_SET_TIME   = 3'd0;
    localparam logic [2:0] EV_SET_ALARM  = 3'd1;
    localparam logic [2:0] EV_STATUS     = 3'd2;
    localparam logic [2:0] EV_FORMAT_ERR = 3'd3;
    localparam logic [2:0] EV_UNKNOWN    = 3'd4;

    localparam logic [1:0] CLS_DATA  = 2'd0;
    localparam logic [1:0] CLS_OPEN  = 2'd1;
    localparam logic [1:0] CLS_CLOSE = 2'd2;

    localparam int WIN_BYTES = 19;
    localparam int TIME_LEN   = 9;
    localparam int ALARM_LEN  = 10;
    localparam int STATUS_LEN = 8;
    localparam int HMS_LEN    = 9;

    localparam byte_t PAT_TIME [TIME_LEN] = '{
        8'h28, 8'h53, 8'h45, 8'h54, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3A};
    localparam byte_t PAT_ALARM [ALARM_LEN] = '{
        8'h28, 8'h53, 8'h45, 8'h54, 8'h41, 8'h4C, 8'h41, 8'h52, 8'h4D, 8'h3A};
    localparam byte_t PAT_STATUS [STATUS_LEN] = '{
        8'h28, 8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53, 8'h29};

    typedef struct packed {
        logic [1:0] cls;
        byte_t      data;
    } ccl_item_t;

    typedef struct packed {
        logic      valid;
        ccl_item_t item;
    } ccl_link_t;

    function automatic logic is_digit(input byte_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [6:0] two_digit_value(input byte_t a, input byte_t b);
        logic [3:0] da;
        logic [3:0] db;
        byte_t      ta;
        byte_t      tb;
        ta = a - CH_ZERO;
        tb = b - CH_ZERO;
        da = ta[3:0];
        db = tb[3:0];
        return {da, 3'b000} + {2'b00, da, 1'b0} + {3'b000, db};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccl_front.sv =====
// Front end: classifies received bytes and queues them for the line engine.
`default_nettype none

module ccl_front
    import ccl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire byte_t     rx_byte,
    output ccl_link_t      link,
    input  wire logic      link_ready
);

    ccl_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;
    ccl_item_t  new_item;

    always_comb
    begin
        new_item.data = rx_byte;
        case (rx_byte)
            CH_OPEN:  new_item.cls = CLS_OPEN;
            CH_CLOSE: new_item.cls = CLS_CLOSE;
            default:  new_item.cls = CLS_DATA;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign link.valid = (cnt_reg != 2'd0);
    assign link.item  = q_reg[rd_ptr_reg];
    assign do_pop     = link.valid && link_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ccl_back.sv =====
// Line engine: keeps the line window and fill count, parses closed lines into events.
`default_nettype none

module ccl_back
    import ccl_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ccl_link_t  link,
    output logic            link_ready,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      event_res,
    output logic [4:0]      hours,
    output logic [5:0]      minutes,
    output logic [5:0]      seconds
);

    localparam int FW = $clog2(LINE_BYTES + 1);
    localparam int IW = $clog2(WIN_BYTES);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PARSE = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    byte_t         win_reg [WIN_BYTES];
    logic          win_we;
    logic [IW-1:0] win_idx;
    byte_t         win_data;

    logic          res_valid_reg;
    logic          res_valid_next;
    logic [2:0]    res_ev_reg;
    logic [4:0]    res_h_reg;
    logic [5:0]    res_m_reg;
    logic [5:0]    res_s_reg;
    logic          res_load;
    logic          take;
    logic          in_window;

    byte_t         b [WIN_BYTES];
    byte_t         hb [HMS_LEN];
    logic          is_time;
    logic          is_alarm;
    logic          is_status;
    logic          hms_ok;
    logic [6:0]    hv;
    logic [6:0]    mv;
    logic [6:0]    sv;
    logic [2:0]    ev;
    logic [4:0]    ph;
    logic [5:0]    pm;
    logic [5:0]    ps;

    assign link_ready = (state_reg == ST_IDLE);
    assign take       = link.valid && link_ready;
    assign in_window  = (fill_reg < FW'(WIN_BYTES));

    always_comb
    begin
        for (int i = 0; i < WIN_BYTES; i++)
        begin
            b[i] = (FW'(i) < fill_reg) ? win_reg[i] : 8'h00;
        end
        is_time = 1'b1;
        for (int i = 0; i < TIME_LEN; i++)
        begin
            if (b[i] != PAT_TIME[i])
            begin
                is_time = 1'b0;
            end
        end
        is_alarm = 1'b1;
        for (int i = 0; i < ALARM_LEN; i++)
        begin
            if (b[i] != PAT_ALARM[i])
            begin
                is_alarm = 1'b0;
            end
        end
        is_status = 1'b1;
        for (int i = 0; i < STATUS_LEN; i++)
        begin
            if (b[i] != PAT_STATUS[i])
            begin
                is_status = 1'b0;
            end
        end
        for (int i = 0; i < HMS_LEN; i++)
        begin
            hb[i] = is_time ? b[TIME_LEN + i] : b[ALARM_LEN + i];
        end
        hv = two_digit_value(hb[0], hb[1]);
        mv = two_digit_value(hb[3], hb[4]);
        sv = two_digit_value(hb[6], hb[7]);
        hms_ok = is_digit(hb[0]) && is_digit(hb[1]) && (hb[2] == CH_COLON)
              && is_digit(hb[3]) && is_digit(hb[4]) && (hb[5] == CH_COLON)
              && is_digit(hb[6]) && is_digit(hb[7]) && (hb[8] == CH_CLOSE)
              && (hv < 7'd24) && (mv < 7'd60) && (sv < 7'd60);
        ph = 5'd0;
        pm = 6'd0;
        ps = 6'd0;
        if (is_time || is_alarm)
        begin
            if (hms_ok)
            begin
                ev = is_time ? EV_SET_TIME : EV_SET_ALARM;
                ph = hv[4:0];
                pm = mv[5:0];
                ps = sv[5:0];
            end
            else
            begin
                ev = EV_FORMAT_ERR;
            end
        end
        else
        begin
            ev = is_status ? EV_STATUS : EV_UNKNOWN;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        win_we     = 1'b0;
        win_idx    = fill_reg[IW-1:0];
        win_data   = link.item.data;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (link.item.cls)
                        CLS_OPEN:
                        begin
                            win_we    = 1'b1;
                            win_idx   = '0;
                            fill_next = FW'(1);
                        end
                        CLS_CLOSE:
                        begin
                            win_we     = in_window;
                            fill_next  = fill_reg + FW'(1);
                            state_next = ST_PARSE;
                        end
                        default:
                        begin
                            if (fill_reg < FW'(LINE_BYTES - 1))
                            begin
                                win_we    = in_window;
                                fill_next = fill_reg + FW'(1);
                            end
                            else
                            begin
                                fill_next = '0;
                            end
                        end
                    endcase
                end
            end
            ST_PARSE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_load   = 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_reg[win_idx] <= win_data;
        end
        if (res_load)
        begin
            res_ev_reg <= ev;
            res_h_reg  <= ph;
            res_m_reg  <= pm;
            res_s_reg  <= ps;
        end
    end

    assign empty     = !res_valid_reg;
    assign event_res = res_ev_reg;
    assign hours     = res_h_reg;
    assign minutes   = res_m_reg;
    assign seconds   = res_s_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/clock_command_line_parser.sv =====
// Top level of the clock command line parser.
//
// Received characters enter on rx_byte and are taken when push is high and
// full is low. A two-item queue separates byte intake from the line engine,
// so intake continues while a parse waits for its result to be taken.
// Each character is an item; only a closing parenthesis produces a result.
// The result sits on event_res, hours, minutes and seconds while empty is
// low and is removed when pop is high at a clock edge.
// An ordinary character is added to the line, and stored if it falls in the
// window; a closing one is added the same way and then parsed: the parse
// step checks the window of the first nineteen line bytes and loads the
// result register.
// Throughput is one item per cycle for ordinary characters while the engine
// is idle; during a parse step the engine takes no new item.
// If the result is not taken, the engine holds in its parse step, the queue
// fills, and full rises until pop frees the result register.
// Reset empties the queue and the result register and clears the line.
`default_nettype none

module clock_command_line_parser
    import ccl_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      event_res,
    output logic [4:0]      hours,
    output logic [5:0]      minutes,
    output logic [5:0]      seconds
);

    ccl_link_t link;
    logic      link_ready;

    ccl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .link       (link),
        .link_ready (link_ready)
    );

    ccl_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .link_ready (link_ready),
        .empty      (empty),
        .pop        (pop),
        .event_res  (event_res),
        .hours      (hours),
        .minutes    (minutes),
        .seconds    (seconds)
    );

endmodule

`default_nettype wire
